[design/afr_pkg.sv]
// Shared types, constants and the CRC-32 byte step for the acknowledgement frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

  localparam int FrameBytes = 32;
  localparam int PosW       = $clog2(FrameBytes);
  localparam int QueueDepth = 2;

  // Byte positions inside a frame.
  localparam logic [PosW-1:0] PosMagicHi  = PosW'(3);
  localparam logic [PosW-1:0] PosIndexLo  = PosW'(4);
  localparam logic [PosW-1:0] PosIndexHi  = PosW'(7);
  localparam logic [PosW-1:0] PosStatus   = PosW'(8);
  localparam logic [PosW-1:0] PosResvLo   = PosW'(9);
  localparam logic [PosW-1:0] PosResvHi   = PosW'(11);
  localparam logic [PosW-1:0] PosOffsetLo = PosW'(12);
  localparam logic [PosW-1:0] PosOffsetHi = PosW'(19);
  localparam logic [PosW-1:0] PosCrcLo    = PosW'(20);
  localparam logic [PosW-1:0] PosCrcHi    = PosW'(23);
  localparam logic [PosW-1:0] PosTailLo   = PosW'(24);
  localparam logic [PosW-1:0] PosLast     = PosW'(FrameBytes - 1);

  localparam logic [7:0] MagicBytes [4] = '{8'h46, 8'h54, 8'h41, 8'h01};

  localparam logic [7:0] StAck = 8'h06;
  localparam logic [7:0] StNak = 8'h15;
  localparam logic [7:0] StCan = 8'h18;

  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcPreset = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_MAGIC  = 3'd1,
    ERR_RESV   = 3'd2,
    ERR_STATUS = 3'd3,
    ERR_CRC    = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    ACT_CURRENT = 3'd0,
    ACT_RETRY   = 3'd1,
    ACT_STALE   = 3'd2,
    ACT_CANCEL  = 3'd3,
    ACT_INVALID = 3'd4
  } act_e;

  // One checked frame plus the context it is classified against.
  typedef struct packed {
    err_e        err;
    logic [31:0] idx;
    logic [7:0]  status;
    logic [63:0] offset;
    logic [31:0] exp_idx;
    logic [63:0] off_before;
    logic [63:0] off_after;
    logic        allow_prev;
  } frame_rec_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/afr_if.sv]
// Valid/ready channel interfaces for the byte input and the frame result.
`timescale 1ns / 1ps
`default_nettype none

interface afr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] await_index;
  logic [63:0] offset_before;
  logic [63:0] offset_after;
  logic        late_ok;

  modport source (output valid, data_byte, await_index, offset_before, offset_after,
                  late_ok, input ready);
  modport sink (input valid, data_byte, await_index, offset_before, offset_after,
                late_ok, output ready);
endinterface

interface afr_out_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [2:0]  error_kind;
  logic [31:0] frame_index;
  logic [7:0]  ack_status;
  logic [63:0] commit_offset;
  logic [2:0]  action;

  modport source (output valid, frame_valid, error_kind, frame_index, ack_status,
                  commit_offset, action, input ready);
  modport sink (input valid, frame_valid, error_kind, frame_index, ack_status,
                commit_offset, action, output ready);
endinterface

`default_nettype wire

[design/afr_front.sv]
// Front part: gathers frame bytes, runs the CRC and checks each completed frame.
`timescale 1ns / 1ps
`default_nettype none

module afr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  afr_in_if.sink                 in_i,
  input  wire logic              q_full_i,
  output      logic              push_o,
  output      afr_pkg::frame_rec_t rec_o
);
  import afr_pkg::*;

  logic [PosW-1:0] cnt_q;
  logic [31:0]     crc_q;
  logic            magic_ok_q;
  logic            resv_ok_q;
  logic [31:0]     idx_q;
  logic [7:0]      status_q;
  logic [63:0]     offset_q;
  logic [31:0]     crc_field_q;

  logic       accept;
  logic       last;
  logic       resv_pos;
  logic       status_ok;
  logic       resv_fin;
  logic [7:0] b;
  err_e       err;

  assign b        = in_i.data_byte;
  assign last     = (cnt_q == PosLast);
  // Only the closing byte needs room in the queue.
  assign in_i.ready = !last || !q_full_i;
  assign accept   = in_i.valid && in_i.ready;
  assign push_o   = accept && last;

  always_comb begin
    resv_pos  = ((cnt_q >= PosResvLo) && (cnt_q <= PosResvHi)) || (cnt_q >= PosTailLo);
    status_ok = (status_q == StAck) || (status_q == StNak) || (status_q == StCan);
    resv_fin  = resv_ok_q && (b == 8'h00);
    priority if (!magic_ok_q) begin
      err = ERR_MAGIC;
    end else if (!resv_fin) begin
      err = ERR_RESV;
    end else if (!status_ok) begin
      err = ERR_STATUS;
    end else if (crc_field_q != ~crc_q) begin
      err = ERR_CRC;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    rec_o.err        = err;
    rec_o.idx        = (err == ERR_NONE) ? idx_q : 32'h0;
    rec_o.status     = (err == ERR_NONE) ? status_q : 8'h00;
    rec_o.offset     = (err == ERR_NONE) ? offset_q : 64'h0;
    rec_o.exp_idx    = in_i.await_index;
    rec_o.off_before = in_i.offset_before;
    rec_o.off_after  = in_i.offset_after;
    rec_o.allow_prev = in_i.late_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= CrcPreset;
    end else if (accept) begin
      cnt_q <= last ? '0 : cnt_q + 1'b1;
      if (last) begin
        crc_q <= CrcPreset;
      end else if (cnt_q < PosCrcLo) begin
        crc_q <= crc32_byte(crc_q, b);
      end
    end
  end

  // Fields are shifted in little-endian, so the first byte ends up lowest.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (cnt_q == '0) begin
        magic_ok_q <= (b == MagicBytes[0]);
      end else if (cnt_q <= PosMagicHi) begin
        magic_ok_q <= magic_ok_q && (b == MagicBytes[cnt_q[1:0]]);
      end
      if (cnt_q == '0) begin
        resv_ok_q <= 1'b1;
      end else if (resv_pos) begin
        resv_ok_q <= resv_ok_q && (b == 8'h00);
      end
      if ((cnt_q >= PosIndexLo) && (cnt_q <= PosIndexHi)) begin
        idx_q <= {b, idx_q[31:8]};
      end
      if (cnt_q == PosStatus) begin
        status_q <= b;
      end
      if ((cnt_q >= PosOffsetLo) && (cnt_q <= PosOffsetHi)) begin
        offset_q <= {b, offset_q[63:8]};
      end
      if ((cnt_q >= PosCrcLo) && (cnt_q <= PosCrcHi)) begin
        crc_field_q <= {b, crc_field_q[31:8]};
      end
    end
  end

endmodule

`default_nettype wire

[design/afr_fifo.sv]
// Short queue of checked frame records between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none

module afr_fifo #(
  parameter int Depth = afr_pkg::QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire afr_pkg::frame_rec_t wdata_i,
  input  wire logic                pop_i,
  output      afr_pkg::frame_rec_t rdata_o,
  output      logic                full_o,
  output      logic                nonempty_o
);
  import afr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  frame_rec_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nonempty_o = (cnt_q != '0);
  assign rdata_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[design/afr_back.sv]
// Back part: classifies a checked frame and holds the result until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module afr_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire afr_pkg::frame_rec_t rec_i,
  input  wire logic                rec_valid_i,
  output      logic                pop_o,
  afr_out_if.source                out_o
);
  import afr_pkg::*;

  logic        out_valid_q;
  logic        frame_valid_q;
  err_e        err_q;
  logic [31:0] idx_q;
  logic [7:0]  status_q;
  logic [63:0] offset_q;
  act_e        act_q;
  act_e        act_d;

  assign pop_o = rec_valid_i && (!out_valid_q || out_o.ready);

  // A failed frame carries zero fields, which always lands on invalid below.
  always_comb begin
    priority if (rec_i.status == StCan) begin
      act_d = ACT_CANCEL;
    end else if (rec_i.idx == rec_i.exp_idx) begin
      priority if ((rec_i.status == StAck) && (rec_i.offset == rec_i.off_after)) begin
        act_d = ACT_CURRENT;
      end else if ((rec_i.status == StNak) && (rec_i.offset == rec_i.off_before)) begin
        act_d = ACT_RETRY;
      end else begin
        act_d = ACT_INVALID;
      end
    end else if (rec_i.allow_prev && (rec_i.exp_idx != 32'h0) && (rec_i.status == StAck)
                 && (rec_i.idx == rec_i.exp_idx - 32'd1)
                 && (rec_i.offset == rec_i.off_before)) begin
      act_d = ACT_STALE;
    end else begin
      act_d = ACT_INVALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      frame_valid_q <= (rec_i.err == ERR_NONE);
      err_q         <= rec_i.err;
      idx_q         <= rec_i.idx;
      status_q      <= rec_i.status;
      offset_q      <= rec_i.offset;
      act_q         <= act_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.frame_valid   = frame_valid_q;
  assign out_o.error_kind    = err_q;
  assign out_o.frame_index   = idx_q;
  assign out_o.ack_status    = status_q;
  assign out_o.commit_offset = offset_q;
  assign out_o.action        = act_q;

endmodule

`default_nettype wire

[design/ack_frame_receiver.sv]
// Top level of the acknowledgement frame receiver: front, record queue and back.
//
//   channel | direction | transfer carries
//   --------+-----------+-----------------------------------------------------
//   in_i    | sink      | one stream byte plus index and offset context
//   out_o   | source    | one checked, classified frame per 32 accepted bytes
//
// One byte is taken per cycle unless a last byte waits on a full queue; the
// CRC in the front advances one byte per cycle over bytes 0 to 19. A frame
// result passes the record queue, then the output register of the back part.
// Reset clears the byte count, presets the CRC and empties the queue.
// A stalled output fills the queue; input stalls only on the last byte of a
// frame while the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module ack_frame_receiver #(
  parameter int QUEUE_DEPTH = afr_pkg::QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  afr_in_if.sink    in_i,
  afr_out_if.source out_o
);
  import afr_pkg::*;

  frame_rec_t push_rec;
  frame_rec_t head_rec;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_nonempty;

  afr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .rec_o    (push_rec)
  );

  afr_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wdata_i    (push_rec),
    .pop_i      (pop),
    .rdata_o    (head_rec),
    .full_o     (q_full),
    .nonempty_o (q_nonempty)
  );

  afr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (head_rec),
    .rec_valid_i (q_nonempty),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!q_full || pop))
    else $error("record pushed into a full queue");

  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_o.valid)
    else $error("popped record not presented at the output");

  a_bad_is_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.frame_valid) |->
      (out_o.action == ACT_INVALID && out_o.error_kind != ERR_NONE))
    else $error("failed frame not classified as invalid");

  a_good_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frame_valid) |-> (out_o.error_kind == ERR_NONE))
    else $error("valid frame carries an error kind");

endmodule

`default_nettype wire
